// ----- sv/neighbor_stats_table_core_assert.svh -----
// Assertion macros shared by the neighbor statistics table RTL.
`ifndef NEIGHBOR_STATS_TABLE_CORE_ASSERT_SVH
`define NEIGHBOR_STATS_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define NST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define NST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/nst_pkg.sv -----
// Package: sizes, codes and shared types of the neighbor statistics table.
package nst_pkg;

  localparam int MAX_NEIGHBORS = 16;
  localparam int IDX_W         = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 8;
  localparam int ENTRY_COUNT_W = 5;

  // Command codes carried in s_axis_tuser; code 3 acts as a query
  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_QUERY   = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  // One table entry as stored in the entry RAM
  typedef struct packed {
    logic [DATA_W-1:0] gaps;
    logic [DATA_W-1:0] frames;
    logic [DATA_W-1:0] seen;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  // Operand set for the shared adder
  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic              carry;
  } alu_rsp_t;

endpackage

// ----- sv/nst_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
module nst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/nst_alu.sv -----
// Shared 32-bit add/subtract unit with carry out (carry set means a >= b on subtract).
module nst_alu (
  input  nst_pkg::alu_req_t req,
  output nst_pkg::alu_rsp_t rsp
);
  import nst_pkg::*;

  logic [DATA_W:0]   full;
  logic [DATA_W-1:0] b_op;

  assign b_op = req.sub ? ~req.b : req.b;
  assign full = {1'b0, req.a} + {1'b0, b_op} + {{DATA_W{1'b0}}, req.sub};

  assign rsp.sum   = full[DATA_W-1:0];
  assign rsp.carry = full[DATA_W];

endmodule

// ----- sv/neighbor_stats_table_core.sv -----
// Top level of the neighbor statistics table: sequencer, entry RAM and shared adder.
// One command is taken at a time, and the input is not ready until the result is loaded
// into the output register. A clear skips the scan and goes straight to loading its result.
// An observe or a query scans the entry RAM linearly, one entry per cycle from index 0, and
// a miss is found once all used entries are scanned. After a hit come up to two passes
// through the shared 32-bit adder (frame and gap update, or age and freshness compare), and
// an update then writes the entry back to the RAM. An observe miss writes a new entry or, when
// the table is full, bumps the drop count through the adder. The next transfer can come in
// the cycle after the result is loaded. While the output register still holds an earlier
// result that has not been taken, the result waits.
`include "neighbor_stats_table_core_assert.svh"

module neighbor_stats_table_core (
  input  logic         clk,
  input  logic         rst,
  // config: stale_after_ms
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,  // address[7:0], now_ms[39:8], gap_count[71:40]
  input  logic [1:0]   s_axis_tuser,  // cmd[1:0]
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,  // rx_frames[31:0], sequence_gaps[63:32],
                                      // last_seen_ms[95:64], entry_count[100:96],
                                      // dropped_count[132:101], zero[135:133]
  output logic [3:0]   m_axis_tuser   // status[2:0], fresh[3]
);
  import nst_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_ADD1  = 6'b000100,
    S_ADD2  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state;
  status_t           status;
  logic [DATA_W-1:0] stale_after_ms;
  logic [CNT_W-1:0]  used;
  logic [DATA_W-1:0] drop_total;
  logic [CNT_W-1:0]  scan_idx;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic [IDX_W-1:0]  wr_idx;
  logic              fresh;
  logic [DATA_W-1:0] age;
  entry_t            ent;
  entry_t            rd_ent;

  // latched command
  logic [1:0]        cmd;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] now_ms;
  logic [DATA_W-1:0] gap_count;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic              in_xfer;
  logic              hit;
  logic              ram_we;
  logic              out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign hit           = pend && (rd_ent.addr == address);
  assign ram_we        = (state == S_WRITE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  nst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_NEIGHBORS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (ent),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (rd_ent)
  );

  nst_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // adder operand select per step
  always_comb begin
    alu_req = '{a: ent.frames, b: DATA_W'(1), sub: 1'b0};
    case (state)
      S_ADD1: begin
        case (status)
          ST_HIT:     alu_req = '{a: now_ms, b: ent.seen, sub: 1'b1};
          ST_DROPPED: alu_req = '{a: drop_total, b: DATA_W'(1), sub: 1'b0};
          default:    alu_req = '{a: ent.frames, b: DATA_W'(1), sub: 1'b0};
        endcase
      end
      S_ADD2: begin
        if (status == ST_HIT) begin
          alu_req = '{a: stale_after_ms, b: age, sub: 1'b1};
        end else begin
          alu_req = '{a: ent.gaps, b: gap_count, sub: 1'b0};
        end
      end
      default: alu_req = '{a: ent.frames, b: DATA_W'(1), sub: 1'b0};
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_after_ms <= '0;
    end else if (cfg_we) begin
      stale_after_ms <= cfg_wdata;
    end
  end

  // result valid: set when a result is loaded, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used          <= '0;
      drop_total    <= '0;
      pend          <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            cmd       <= s_axis_tuser;
            address   <= s_axis_tdata[7:0];
            now_ms    <= s_axis_tdata[39:8];
            gap_count <= s_axis_tdata[71:40];
            fresh     <= 1'b0;
            scan_idx  <= '0;
            pend      <= 1'b0;
            if (s_axis_tuser == CMD_CLEAR) begin
              used       <= '0;
              drop_total <= '0;
              ent        <= '0;
              status     <= ST_CLEARED;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            pend   <= 1'b0;
            ent    <= rd_ent;
            wr_idx <= pend_idx;
            status <= (cmd == CMD_OBSERVE) ? ST_UPDATED : ST_HIT;
            state  <= S_ADD1;
          end else if (scan_idx != used) begin
            pend     <= 1'b1;
            pend_idx <= scan_idx[IDX_W-1:0];
            scan_idx <= scan_idx + CNT_W'(1);
          end else begin
            // miss: insert, drop, or report the miss
            pend <= 1'b0;
            if (cmd != CMD_OBSERVE) begin
              ent    <= '0;
              status <= ST_MISS;
              state  <= S_DONE;
            end else if (used == CNT_W'(MAX_NEIGHBORS)) begin
              ent    <= '0;
              status <= ST_DROPPED;
              state  <= S_ADD1;
            end else begin
              ent    <= '{gaps: gap_count, frames: DATA_W'(1), seen: now_ms, addr: address};
              wr_idx <= used[IDX_W-1:0];
              status <= ST_INSERTED;
              state  <= S_WRITE;
            end
          end
        end
        S_ADD1: begin
          case (status)
            ST_HIT: begin
              age   <= alu_rsp.sum;
              state <= S_ADD2;
            end
            ST_DROPPED: begin
              drop_total <= alu_rsp.sum;
              state      <= S_DONE;
            end
            default: begin
              ent.frames <= alu_rsp.sum;
              ent.seen   <= now_ms;
              state      <= S_ADD2;
            end
          endcase
        end
        S_ADD2: begin
          if (status == ST_HIT) begin
            fresh <= alu_rsp.carry;
            state <= S_DONE;
          end else begin
            ent.gaps <= alu_rsp.sum;
            state    <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (status == ST_INSERTED) begin
            used <= used + CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // hand the result to the output register
          if (out_free) begin
            m_axis_tdata  <= {3'b000, drop_total, ENTRY_COUNT_W'(used),
                              ent.seen, ent.gaps, ent.frames};
            m_axis_tuser  <= {fresh, status};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `NST_ASSERT_SAME(a_used_bound, 1'b1, used <= CNT_W'(MAX_NEIGHBORS),
                   "entry count past table size")
  `NST_ASSERT_NEXT(a_insert_count, (state == S_WRITE) && (status == ST_INSERTED),
                   used == $past(used) + CNT_W'(1), "insert did not bump entry count")
  `NST_ASSERT_SAME(a_fresh_hit, m_axis_tvalid && m_axis_tuser[3],
                   m_axis_tuser[2:0] == ST_HIT, "fresh flag outside a query hit")
  `NST_ASSERT_NEXT(a_accept_next, in_xfer, (state == S_SCAN) || (state == S_DONE),
                   "transfer did not start a command")

endmodule
